// File: src/median_filter_3x3_macros.svh
// Assertion macros used by the checker file of the median filter.
`ifndef MEDIAN_FILTER_3X3_MACROS_SVH
`define MEDIAN_FILTER_3X3_MACROS_SVH

// Same-cycle implication, switched off while reset is asserted.
`define MF3X3_ASSERT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, switched off while reset is asserted.
`define MF3X3_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: src/mf3x3_pkg.sv
package mf3x3_pkg;

    // Line store geometry.
    localparam int MAX_LINE_WIDTH = 1024;
    localparam int COL_W          = (MAX_LINE_WIDTH > 1) ? $clog2(MAX_LINE_WIDTH) : 1;
    localparam int PIX_W          = 8;
    localparam int LINE_W         = 2 * PIX_W;

    // Configuration register widths and reset values.
    localparam int WIDTH_W        = 11;
    localparam int ROW_W          = 12;
    localparam int MIN_DIM        = 3;
    localparam int WIDTH_RESET    = 720;
    localparam int HEIGHT_RESET   = 480;

    // Column compares need room for the width itself and for column plus one.
    localparam int CMP_W          = (COL_W + 1 > WIDTH_W) ? COL_W + 1 : WIDTH_W;

    // Result coordinate widths.
    localparam int OUT_ROW_W      = 12;
    localparam int OUT_COL_W      = 10;

    // Configuration port.
    localparam int CFG_IDX_W      = 1;
    localparam int CFG_DATA_W     = 12;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 1'b1;

    typedef struct packed {
        logic [PIX_W-1:0] pixel_value;
        logic             frame_start;
    } t_pixel_in;

    typedef struct packed {
        logic [PIX_W-1:0]     median_value;
        logic [OUT_ROW_W-1:0] out_row;
        logic [OUT_COL_W-1:0] out_col;
    } t_pixel_out;

    typedef struct packed {
        logic [PIX_W-1:0] lo;
        logic [PIX_W-1:0] md;
        logic [PIX_W-1:0] hi;
    } t_sort3;

    function automatic logic [PIX_W-1:0] min2(input logic [PIX_W-1:0] a,
                                              input logic [PIX_W-1:0] b);
        return (a < b) ? a : b;
    endfunction

    function automatic logic [PIX_W-1:0] max2(input logic [PIX_W-1:0] a,
                                              input logic [PIX_W-1:0] b);
        return (a < b) ? b : a;
    endfunction

    // Sorts three values with three compare-exchange steps.
    function automatic t_sort3 sort3(input logic [PIX_W-1:0] a,
                                     input logic [PIX_W-1:0] b,
                                     input logic [PIX_W-1:0] c);
        logic [PIX_W-1:0] lo_ab;
        logic [PIX_W-1:0] hi_ab;
        t_sort3           s;
        lo_ab = min2(a, b);
        hi_ab = max2(a, b);
        s.lo  = min2(lo_ab, c);
        s.hi  = max2(hi_ab, c);
        s.md  = max2(lo_ab, min2(hi_ab, c));
        return s;
    endfunction

    function automatic logic [PIX_W-1:0] max3(input logic [PIX_W-1:0] a,
                                              input logic [PIX_W-1:0] b,
                                              input logic [PIX_W-1:0] c);
        return max2(max2(a, b), c);
    endfunction

    function automatic logic [PIX_W-1:0] min3(input logic [PIX_W-1:0] a,
                                              input logic [PIX_W-1:0] b,
                                              input logic [PIX_W-1:0] c);
        return min2(min2(a, b), c);
    endfunction

    function automatic logic [PIX_W-1:0] med3(input logic [PIX_W-1:0] a,
                                              input logic [PIX_W-1:0] b,
                                              input logic [PIX_W-1:0] c);
        return max2(min2(a, b), min2(max2(a, b), c));
    endfunction

endpackage

// File: src/mf3x3_ram.sv
module mf3x3_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                                           i_clk,
    input  logic                                           i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]   i_waddr,
    input  logic [WIDTH-1:0]                               i_wdata,
    input  logic                                           i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]   i_raddr,
    output logic [WIDTH-1:0]                               o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // A read at the address being written returns the old contents.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: src/median_filter_3x3.sv
// 3x3 median filter over a raster stream of 8-bit luma pixels. One item is
// accepted per clock cycle while the output is not stalled; the line store
// is a 1024 x 16 memory with one read and one write per cycle, and each item
// makes one read and one write-back of its column entry. A result passes
// stages 1 to 4 and the output register once the item that completes its
// window is accepted, i.e. on the arrival of pixel (r, c) with r and c of at
// least 2 the median centered on (r-1, c-1) comes out; border positions give
// no item. The line store needs no clearing after reset, so items are taken
// at once. image_width (index 0) and image_height (index 1) are clamped to
// 3..1024 and 3..4095 and should be written only while the filter is idle.
module median_filter_3x3
    import mf3x3_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data,
    input  logic                   i_in_valid,
    output logic                   o_in_stall,
    input  t_pixel_in              i_in_data,
    output logic                   o_out_valid,
    input  logic                   i_out_stall,
    output t_pixel_out             o_out_data
);

    // Configuration registers.
    logic [WIDTH_W-1:0] r_image_width;
    logic [ROW_W-1:0]   r_image_height;

    // Position of the next pixel.
    logic [COL_W-1:0]   r_col;
    logic [ROW_W-1:0]   r_row;
    logic [COL_W-1:0]   n_col;
    logic [ROW_W-1:0]   n_row;

    // Position of the item being accepted.
    logic [CMP_W-1:0]   w_raw;
    logic [CMP_W-1:0]   w_use;
    logic [ROW_W-1:0]   h_use;
    logic [COL_W-1:0]   c_start;
    logic [ROW_W-1:0]   row_start;
    logic [ROW_W-1:0]   row_wrap;
    logic [COL_W-1:0]   acc_col;
    logic [ROW_W-1:0]   acc_row;
    logic [ROW_W-1:0]   row_inc;
    logic [CMP_W-1:0]   col_inc;
    logic               acc_emit;
    logic               accept;

    // Stage 1: line store read returns.
    logic               r1_valid;
    logic [PIX_W-1:0]   r1_pix;
    logic [COL_W-1:0]   r1_col;
    logic [ROW_W-1:0]   r1_row;
    logic               r1_emit;
    logic               r1_fwd;
    logic [LINE_W-1:0]  r1_fwd_data;
    logic [LINE_W-1:0]  ram_rdata;
    logic [LINE_W-1:0]  s1_entry;
    logic [PIX_W-1:0]   s1_top;
    logic [PIX_W-1:0]   s1_mid;
    logic [LINE_W-1:0]  s1_wdata;
    logic               s1_adv;
    logic [PIX_W-1:0]   r_win [6];

    // Stage 2 to 4 and output register.
    logic                 r2_valid;
    logic [PIX_W-1:0]     r2_nb [9];
    logic [OUT_ROW_W-1:0] r2_row;
    logic [OUT_COL_W-1:0] r2_col;
    logic                 r3_valid;
    t_sort3               r3_sort [3];
    logic [OUT_ROW_W-1:0] r3_row;
    logic [OUT_COL_W-1:0] r3_col;
    logic                 r4_valid;
    logic [PIX_W-1:0]     r4_cand [3];
    logic [OUT_ROW_W-1:0] r4_row;
    logic [OUT_COL_W-1:0] r4_col;
    logic                 r_out_valid;
    t_pixel_out           r_out_data;

    logic               out_free;
    logic               s4_free;
    logic               s3_free;
    logic               s2_free;

    // Configuration writes; the port is always ready.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_image_width  <= WIDTH_W'(WIDTH_RESET);
            r_image_height <= ROW_W'(HEIGHT_RESET);
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_IMAGE_WIDTH:  r_image_width  <= i_cfg_data[WIDTH_W-1:0];
                REG_IMAGE_HEIGHT: r_image_height <= i_cfg_data[ROW_W-1:0];
                default: ;
            endcase
        end
    end

    // Clamp the dimensions. The height field cannot exceed the row limit.
    always_comb begin
        w_raw = CMP_W'(r_image_width);
        if (w_raw < CMP_W'(MIN_DIM)) begin
            w_use = CMP_W'(MIN_DIM);
        end else if (w_raw > CMP_W'(MAX_LINE_WIDTH)) begin
            w_use = CMP_W'(MAX_LINE_WIDTH);
        end else begin
            w_use = w_raw;
        end
        h_use = (r_image_height < ROW_W'(MIN_DIM)) ? ROW_W'(MIN_DIM) : r_image_height;
    end

    // Handshake: stage 1 takes an item when it is empty or moving on.
    assign accept     = i_in_valid && !o_in_stall;
    assign out_free   = !r_out_valid || !i_out_stall;
    assign s4_free    = !r4_valid || out_free;
    assign s3_free    = !r3_valid || s4_free;
    assign s2_free    = !r2_valid || s3_free;
    assign s1_adv     = r1_valid && (!r1_emit || s2_free);
    assign o_in_stall = r1_valid && !s1_adv;

    // Position of the incoming item and of the one after it.
    always_comb begin
        c_start   = i_in_data.frame_start ? '0 : r_col;
        row_start = i_in_data.frame_start ? '0 : r_row;
        if (CMP_W'(c_start) >= w_use) begin
            acc_col  = '0;
            row_wrap = row_start + 1'b1;
        end else begin
            acc_col  = c_start;
            row_wrap = row_start;
        end
        acc_row  = (row_wrap >= h_use) ? '0 : row_wrap;
        acc_emit = (acc_row >= ROW_W'(2)) && (acc_col >= COL_W'(2));

        col_inc = CMP_W'(acc_col) + 1'b1;
        row_inc = acc_row + 1'b1;
        if (col_inc >= w_use) begin
            n_col = '0;
            n_row = (row_inc >= h_use) ? '0 : row_inc;
        end else begin
            n_col = col_inc[COL_W-1:0];
            n_row = acc_row;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (accept) begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

    // Line store: read at accept, write back when the item leaves stage 1.
    mf3x3_ram #(
        .WIDTH (LINE_W),
        .DEPTH (MAX_LINE_WIDTH)
    ) u_line_store (
        .i_clk   (i_clk),
        .i_we    (s1_adv),
        .i_waddr (r1_col),
        .i_wdata (s1_wdata),
        .i_re    (accept),
        .i_raddr (acc_col),
        .o_rdata (ram_rdata)
    );

    // Forward the write-back when the next item reads the same column.
    assign s1_entry = r1_fwd ? r1_fwd_data : ram_rdata;
    assign s1_top   = s1_entry[LINE_W-1:PIX_W];
    assign s1_mid   = s1_entry[PIX_W-1:0];
    assign s1_wdata = {s1_mid, r1_pix};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r1_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r1_pix      <= i_in_data.pixel_value;
            r1_col      <= acc_col;
            r1_row      <= acc_row;
            r1_emit     <= acc_emit;
            r1_fwd      <= s1_adv && (r1_col == acc_col);
            r1_fwd_data <= s1_wdata;
        end
    end

    // Window of the two previous columns, shifted once per item.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 6; i++) begin
                r_win[i] <= '0;
            end
        end else if (s1_adv) begin
            r_win[0] <= r_win[1];
            r_win[1] <= s1_top;
            r_win[2] <= r_win[3];
            r_win[3] <= s1_mid;
            r_win[4] <= r_win[5];
            r_win[5] <= r1_pix;
        end
    end

    // Stage 2: capture the nine neighbors of an interior position.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_valid <= 1'b0;
        end else if (s2_free) begin
            r2_valid <= s1_adv && r1_emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s2_free) begin
            r2_nb[0] <= r_win[0];
            r2_nb[1] <= r_win[1];
            r2_nb[2] <= s1_top;
            r2_nb[3] <= r_win[2];
            r2_nb[4] <= r_win[3];
            r2_nb[5] <= s1_mid;
            r2_nb[6] <= r_win[4];
            r2_nb[7] <= r_win[5];
            r2_nb[8] <= r1_pix;
            r2_row   <= OUT_ROW_W'(r1_row - 1'b1);
            r2_col   <= OUT_COL_W'(r1_col - 1'b1);
        end
    end

    // Stage 3: sort each row of three.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_valid <= 1'b0;
        end else if (s3_free) begin
            r3_valid <= r2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s3_free) begin
            for (int i = 0; i < 3; i++) begin
                r3_sort[i] <= sort3(r2_nb[3*i], r2_nb[3*i+1], r2_nb[3*i+2]);
            end
            r3_row <= r2_row;
            r3_col <= r2_col;
        end
    end

    // Stage 4: largest minimum, middle median, smallest maximum.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_valid <= 1'b0;
        end else if (s4_free) begin
            r4_valid <= r3_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s4_free) begin
            r4_cand[0] <= max3(r3_sort[0].lo, r3_sort[1].lo, r3_sort[2].lo);
            r4_cand[1] <= med3(r3_sort[0].md, r3_sort[1].md, r3_sort[2].md);
            r4_cand[2] <= min3(r3_sort[0].hi, r3_sort[1].hi, r3_sort[2].hi);
            r4_row     <= r3_row;
            r4_col     <= r3_col;
        end
    end

    // Output register: the median of the three candidates.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= r4_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free) begin
            r_out_data.median_value <= med3(r4_cand[0], r4_cand[1], r4_cand[2]);
            r_out_data.out_row      <= r4_row;
            r_out_data.out_col      <= r4_col;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

// File: src/mf3x3_checker.sv
`include "median_filter_3x3_macros.svh"

module mf3x3_checker
    import mf3x3_pkg::*;
(
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   i_cfg_valid,
    input logic                   o_cfg_ready,
    input logic [CFG_IDX_W-1:0]   i_cfg_index,
    input logic [CFG_DATA_W-1:0]  i_cfg_data,
    input logic                   i_in_valid,
    input logic                   o_in_stall,
    input t_pixel_in              i_in_data,
    input logic                   o_out_valid,
    input logic                   i_out_stall,
    input t_pixel_out             o_out_data
);

    // A stalled result item stays offered and unchanged.
    `MF3X3_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall, o_out_valid, "result item dropped while stalled")
    `MF3X3_ASSERT_NEXT(a_out_stable, i_clk, i_rst_n, o_out_valid && i_out_stall, $stable(o_out_data), "stalled result item changed")

    // Results only ever name interior positions.
    `MF3X3_ASSERT(a_col_interior, i_clk, i_rst_n, o_out_valid, (o_out_data.out_col >= OUT_COL_W'(1)) && (o_out_data.out_col <= OUT_COL_W'(MAX_LINE_WIDTH - 2)), "result column on the border")
    `MF3X3_ASSERT(a_row_interior, i_clk, i_rst_n, o_out_valid, (o_out_data.out_row >= OUT_ROW_W'(1)) && (o_out_data.out_row <= OUT_ROW_W'(4093)), "result row on the border")

endmodule

bind median_filter_3x3 mf3x3_checker u_mf3x3_checker (.*);
